// ----- rtl/lap_pkg.sv -----
// shared types, constants and sine table generator for the lfo auto panner
package lap_pkg;

  localparam int SINE_INDEX_BITS_DEF = 8;
  localparam int SAMPLE_WIDTH_DEF    = 16;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PHASE_STEP = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MIX_LEVEL  = 1'd1;

  localparam logic [31:0] PHASE_STEP_RST = 32'd187905;
  localparam logic [15:0] Q15_ONE        = 16'h8000;
  localparam logic [15:0] MIX_LEVEL_RST  = Q15_ONE;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

  // left and right gains, unsigned q2.15 in 0..65536
  typedef struct packed {
    logic [16:0] left;
    logic [16:0] right;
  } lap_gain_t;

  // entry k of the quarter-wave table, round(32768 * sin(k * pi/2 / 2^ib)),
  // taylor series in q30 evaluated at elaboration
  function automatic logic [15:0] sine_entry(input int k, input int ib);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint          s;
    longint          q;
    x  = (HALF_PI_Q30 * longint'(k)) >> ib;
    x2 = (x * x) >> 30;
    t  = x;
    s  = longint'(x);
    t  = ((t * x2) >> 30) / 6;   s = s - longint'(t);
    t  = ((t * x2) >> 30) / 20;  s = s + longint'(t);
    t  = ((t * x2) >> 30) / 42;  s = s - longint'(t);
    t  = ((t * x2) >> 30) / 72;  s = s + longint'(t);
    t  = ((t * x2) >> 30) / 110; s = s - longint'(t);
    t  = ((t * x2) >> 30) / 156; s = s + longint'(t);
    t  = ((t * x2) >> 30) / 210; s = s - longint'(t);
    if (s < 0) begin
      s = 0;
    end
    q = (s + 16384) >>> 15;
    if (q > 32768) begin
      q = 32768;
    end
    return 16'(q);
  endfunction

endpackage

// ----- rtl/lap_lfo.sv -----
// phase accumulator, quarter-wave sine lookup and pan gain computation
module lap_lfo #(
  parameter int SINE_INDEX_BITS = lap_pkg::SINE_INDEX_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               start,
  input  logic [31:0]        phase_step,
  input  logic [15:0]        mix_level,
  output lap_pkg::lap_gain_t gain,
  output logic               gain_valid
);
  import lap_pkg::*;

  localparam int SINE_N = 1 << SINE_INDEX_BITS;
  localparam logic [SINE_INDEX_BITS:0] SINE_N_ADDR = {1'b1, {SINE_INDEX_BITS{1'b0}}};

  logic [15:0] sine_rom [0:SINE_N];

  for (genvar k = 0; k <= SINE_N; k++) begin : g_rom
    assign sine_rom[k] = sine_entry(k, SINE_INDEX_BITS);
  end

  logic [31:0]                lfo_phase;
  logic [31:0]                phase_next;
  logic [SINE_INDEX_BITS-1:0] idx;
  logic [SINE_INDEX_BITS:0]   addr_next;
  logic [SINE_INDEX_BITS:0]   addr;
  logic [15:0]                sine;
  logic [31:0]                prod;
  logic [15:0]                mix_c;
  logic [31:0]                pan_sum;
  logic [15:0]                pan_r;
  logic [15:0]                pan;
  logic                       v1, v2, v3;

  assign phase_next = lfo_phase + phase_step;
  assign idx        = phase_next[29 -: SINE_INDEX_BITS];
  // bit 30 picks the falling quarter, bit 31 drops out with the absolute value
  assign addr_next  = phase_next[30] ? (SINE_N_ADDR - {1'b0, idx}) : {1'b0, idx};

  assign mix_c   = (mix_level > Q15_ONE) ? Q15_ONE : mix_level;
  assign pan_sum = prod + 32'd16384;
  assign pan_r   = pan_sum[30:15];
  assign pan     = (pan_r > mix_c) ? mix_c : pan_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      lfo_phase  <= '0;
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      gain_valid <= 1'b0;
    end else if (en) begin
      if (start) begin
        lfo_phase <= phase_next;
      end
      v1         <= start;
      v2         <= v1;
      v3         <= v2;
      gain_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      addr       <= addr_next;
      sine       <= sine_rom[addr];
      prod       <= sine * mix_c;
      gain.left  <= {1'b0, pan} + 17'h08000 - {1'b0, mix_c};
      gain.right <= 17'h10000 - {1'b0, pan} - {1'b0, mix_c};
    end
  end

endmodule

// ----- rtl/lap_lane.sv -----
// one channel lane: sample times gain, rounded and saturated
module lap_lane #(
  parameter int SAMPLE_WIDTH = lap_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           en,
  input  logic signed [SAMPLE_WIDTH-1:0] sample,
  input  logic        [16:0]             gain,
  output logic signed [SAMPLE_WIDTH-1:0] result
);
  localparam int PW = SAMPLE_WIDTH + 18;
  localparam int QW = PW - 15;
  localparam logic signed [QW-1:0] QMAX = QW'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [QW-1:0] QMIN = -QMAX - QW'(1);

  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] rnd;
  logic signed [QW-1:0] q;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PW'(sample) * $signed({1'b0, gain});
    end
  end

  // floor of (prod + half) / 32768
  assign rnd = prod + PW'(16384);
  assign q   = rnd[PW-1:15];

  always_comb begin
    priority if (q > QMAX) begin
      result = QMAX[SAMPLE_WIDTH-1:0];
    end else if (q < QMIN) begin
      result = QMIN[SAMPLE_WIDTH-1:0];
    end else begin
      result = q[SAMPLE_WIDTH-1:0];
    end
  end

endmodule

// ----- rtl/lfo_auto_panner.sv -----
// top level of the stereo auto panner: config registers, lanes and output register
//
// Stereo auto panner driven by a sine lfo. Each accepted frame advances a
// 32-bit phase accumulator by phase_step, looks up |sin| in a quarter-wave
// table, forms pan = |sin| * mix and scales the left sample by
// (pan + 1 - mix) and the right sample by ((1 - pan) + 1 - mix), both in
// q2.15, rounded half up and saturated. From the input transaction to the
// output being valid, the transaction edge loads the new phase and the
// table address, then table read, pan multiply, gain forming, lane multiply
// and round/saturate into the output register each have a register stage.
// One frame is taken every cycle while the output side keeps taking
// results; the whole pipeline holds while a finished result waits on
// m_axis_tready, and s_axis_tready is low for that time. The phase add is
// the only loop. Configuration writes go straight
// to the registers, so they belong only in times when no frame is in flight.
module lfo_auto_panner #(
  parameter int SINE_INDEX_BITS = lap_pkg::SINE_INDEX_BITS_DEF,
  parameter int SAMPLE_WIDTH    = lap_pkg::SAMPLE_WIDTH_DEF,
  localparam int TDATA_W        = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write port
  input  logic                             cfg_we,
  input  logic [lap_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [lap_pkg::CFG_DATA_W-1:0]   cfg_data,
  // input frames
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [TDATA_W-1:0]               s_axis_tdata,   // left_in, right_in, zero pad
  // output frames
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [TDATA_W-1:0]               m_axis_tdata    // left_out, right_out, zero pad
);
  import lap_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int DELAY = 4;   // lfo stages ahead of the lanes

  logic [31:0] phase_step;
  logic [15:0] mix_level;

  // config registers, written by index
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step <= PHASE_STEP_RST;
      mix_level  <= MIX_LEVEL_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_PHASE_STEP: phase_step <= cfg_data[31:0];
        REG_MIX_LEVEL:  mix_level  <= cfg_data[15:0];
        default:        ;
      endcase
    end
  end

  // global advance: everything moves unless a result waits at the output
  logic en;
  logic start;

  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;
  assign start         = s_axis_tvalid && en;

  lap_gain_t gain;
  logic      gain_valid;

  lap_lfo #(
    .SINE_INDEX_BITS(SINE_INDEX_BITS)
  ) u_lfo (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .start     (start),
    .phase_step(phase_step),
    .mix_level (mix_level),
    .gain      (gain),
    .gain_valid(gain_valid)
  );

  // samples ride alongside the lfo stages so they meet their gains
  logic signed [SW-1:0] left_d  [0:DELAY-1];
  logic signed [SW-1:0] right_d [0:DELAY-1];

  always_ff @(posedge clk) begin
    if (en) begin
      left_d[0]  <= s_axis_tdata[SW-1:0];
      right_d[0] <= s_axis_tdata[2*SW-1:SW];
      for (int i = 1; i < DELAY; i++) begin
        left_d[i]  <= left_d[i-1];
        right_d[i] <= right_d[i-1];
      end
    end
  end

  // one lane per channel
  logic signed [SW-1:0] left_res;
  logic signed [SW-1:0] right_res;
  logic                 lane_valid;

  lap_lane #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_lane_left (
    .clk   (clk),
    .en    (en),
    .sample(left_d[DELAY-1]),
    .gain  (gain.left),
    .result(left_res)
  );

  lap_lane #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH)
  ) u_lane_right (
    .clk   (clk),
    .en    (en),
    .sample(right_d[DELAY-1]),
    .gain  (gain.right),
    .result(right_res)
  );

  // merge stage: both lanes into one output transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      lane_valid    <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      lane_valid    <= gain_valid;
      m_axis_tvalid <= lane_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata <= TDATA_W'({right_res, left_res});
    end
  end

endmodule

// ----- test/lfo_auto_panner_tb.sv -----
// self-checking testbench for the lfo auto panner with a frame scoreboard
module lfo_auto_panner_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lap_pkg::*;

  localparam int TDATA_W        = 32;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int HOLD_CYCLES    = 60;

  // expected-frame store plus its own copy of the phase accumulator and registers
  class pan_scoreboard;
    localparam int SINE_BITS = SINE_INDEX_BITS_DEF;
    localparam int SINE_N    = 1 << SINE_BITS;

    typedef struct packed {
      logic [15:0] right;
      logic [15:0] left;
    } frame_t;

    int unsigned sine_q15 [0:SINE_N];
    logic [31:0] lfo_phase;
    logic [31:0] phase_inc;
    logic [15:0] mix_level;
    frame_t      expected_frames [$];
    int          errors;

    function new();
      longint unsigned x, x2, term, kk, div;
      longint          sum, q;
      int              k, n;
      // quarter-wave |sin| table in q1.15 from a q30 taylor series
      for (k = 0; k <= SINE_N; k++) begin
        kk   = k;
        x    = (HALF_PI_Q30 * kk) / SINE_N;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (n = 1; n <= 7; n++) begin
          div  = (2 * n) * (2 * n + 1);
          term = ((term * x2) >> 30) / div;
          if (n % 2 == 1) begin
            sum = sum - longint'(term);
          end else begin
            sum = sum + longint'(term);
          end
        end
        if (sum < 0) begin
          sum = 0;
        end
        q = (sum + 16384) / 32768;
        if (q > 32768) begin
          q = 32768;
        end
        sine_q15[k] = 32'(q);
      end
      lfo_phase = '0;
      phase_inc = PHASE_STEP_RST;
      mix_level = MIX_LEVEL_RST;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
      case (addr)
        REG_PHASE_STEP: phase_inc = data;
        REG_MIX_LEVEL:  mix_level = data[15:0];
        default: ;
      endcase
    endfunction

    // q2.15 gain, rounded half up, saturated to 16 bits
    function logic [15:0] apply_gain(logic signed [15:0] x, int unsigned g);
      longint v, q, gg;
      gg = g;
      v  = longint'(x) * gg + 16384;
      q  = v >>> 15;
      if (q > 32767) begin
        q = 32767;
      end
      if (q < -32768) begin
        q = -32768;
      end
      return q[15:0];
    endfunction

    // advance the lfo and queue the panned frame for an accepted input
    function void note_frame(logic [15:0] left, logic [15:0] right);
      int unsigned mix, idx, s, pan, gain_l, gain_r;
      frame_t      f;
      lfo_phase = lfo_phase + phase_inc;
      mix = (mix_level > Q15_ONE) ? 32768 : mix_level;
      idx = (lfo_phase >> (30 - SINE_BITS)) & (SINE_N - 1);
      s   = lfo_phase[30] ? sine_q15[SINE_N - idx] : sine_q15[idx];
      pan = (s * mix + 16384) >> 15;
      if (pan > mix) begin
        pan = mix;
      end
      gain_l  = pan + 32768 - mix;
      gain_r  = 65536 - pan - mix;
      f.left  = apply_gain(left, gain_l);
      f.right = apply_gain(right, gain_r);
      expected_frames.push_back(f);
    endfunction

    function void check_frame(logic [15:0] left, logic [15:0] right);
      frame_t f;
      if (expected_frames.size() == 0) begin
        $display("%0t: unexpected result left %0d right %0d", $realtime,
                 $signed(left), $signed(right));
        errors++;
        return;
      end
      f = expected_frames.pop_front();
      if (left !== f.left) begin
        $display("%0t: left_out expected %0d actual %0d", $realtime,
                 $signed(f.left), $signed(left));
        errors++;
      end
      if (right !== f.right) begin
        $display("%0t: right_out expected %0d actual %0d", $realtime,
                 $signed(f.right), $signed(right));
        errors++;
      end
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [TDATA_W-1:0]    s_axis_tdata;   // left_in, right_in
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [TDATA_W-1:0]    m_axis_tdata;   // left_out, right_out

  pan_scoreboard sb;

  // idling controls for the stimulus and the result sink, and the watchdog's idle count
  bit send_gaps;
  bit sink_gaps;
  int hold_len;
  int idle_cycles;

  lfo_auto_panner dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // result sink: random stall bursts, plus a long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len != 0) begin
        // long hold-off so the pipeline fills and the input side stalls
        m_axis_tready <= 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      m_axis_tready <= 1'b1;
    end
  end

  // sample both handshakes at the rising edge; the watchdog counts dead cycles
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else begin
      // output side first: its expectation was queued by an earlier input transaction
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_frame(m_axis_tdata[15:0], m_axis_tdata[31:16]);
      end
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_frame(s_axis_tdata[15:0], s_axis_tdata[31:16]);
      end
      if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // register write, one cycle of cfg_we; the block must be idle
  task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_addr <= addr;
    cfg_data <= data;
    sb.write_reg(addr, data);
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  // offer one frame, with an optional idle burst first, and wait for its transaction
  task automatic send_frame(logic [15:0] left, logic [15:0] right);
    @(negedge clk);
    if (send_gaps && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {right, left};
    do begin
      @(posedge clk);
    end while (!(s_axis_tvalid && s_axis_tready));
  endtask

  // drop tvalid and let every queued frame come back
  task automatic drain();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) begin
      @(posedge clk);
    end
  endtask

  // full-scale and near-zero values show up often, the rest is uniform
  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7fff;
      2:       return 16'($urandom_range(0, 8) - 4);
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_phase(logic [31:0] inc, logic [15:0] mix, int count);
    write_reg(REG_PHASE_STEP, inc);
    write_reg(REG_MIX_LEVEL, {16'd0, mix});
    repeat (count) send_frame(pick_sample(), pick_sample());
    drain();
  endtask

  initial begin
    logic [15:0] corners [5];
    logic [15:0] mix_pick;

    sb            = new();
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_addr      = '0;
    cfg_data      = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    send_gaps     = 1'b1;
    sink_gaps     = 1'b1;
    hold_len      = 0;
    corners       = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: every pairing of sample extremes at the reset settings
    foreach (corners[i]) begin
      foreach (corners[j]) begin
        send_frame(corners[i], corners[j]);
      end
    end
    drain();

    // quarter-turn step lands exactly on sin peaks and zeros; the sink
    // holds off for a long stretch meanwhile
    send_gaps = 1'b0;
    hold_len  = HOLD_CYCLES;
    run_phase(32'h4000_0000, Q15_ONE, 40);
    send_gaps = 1'b1;

    // no mix: right gain is two, so full-scale samples saturate
    run_phase(32'h0000_0000, 16'h0000, 30);

    // largest step wraps the accumulator each frame; mix above full is clipped
    run_phase(32'hffff_ffff, 16'hffff, 50);

    // random steps, mix mostly in range, sometimes above full
    repeat (3) begin
      mix_pick = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(32769, 65535))
                                             : 16'($urandom_range(0, 32768));
      run_phase($urandom, mix_pick, 50);
    end

    // one table entry per frame; the frames cover a quarter of the quarter wave
    run_phase(32'h0040_0000, 16'h4000, 64);

    // last stretch with no idling on either side
    send_gaps = 1'b0;
    sink_gaps = 1'b0;
    run_phase($urandom, 16'h7fff, 60);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ----- lfo_auto_panner.f -----
rtl/lap_pkg.sv
rtl/lap_lfo.sv
rtl/lap_lane.sv
rtl/lfo_auto_panner.sv
test/lfo_auto_panner_tb.sv
